### design/sts_pkg.sv
// shared types and constants for the script token scanner
// used by sts_front, sts_queue, sts_back and script_token_scanner; no dependencies
package sts_pkg;

    // scanner modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_LT   = 3'd1;
    localparam logic [2:0] MODE_GT   = 3'd2;
    localparam logic [2:0] MODE_EQ   = 3'd3;
    localparam logic [2:0] MODE_STR  = 3'd4;
    localparam logic [2:0] MODE_NUM  = 3'd5;
    localparam logic [2:0] MODE_NAME = 3'd6;

    // token types
    localparam logic [3:0] TK_EOF    = 4'd0;
    localparam logic [3:0] TK_LT     = 4'd1;
    localparam logic [3:0] TK_LE     = 4'd2;
    localparam logic [3:0] TK_GT     = 4'd3;
    localparam logic [3:0] TK_GE     = 4'd4;
    localparam logic [3:0] TK_ASSIGN = 4'd5;
    localparam logic [3:0] TK_EQ     = 4'd6;
    localparam logic [3:0] TK_STRING = 4'd7;
    localparam logic [3:0] TK_NUMBER = 4'd8;
    localparam logic [3:0] TK_NAME   = 4'd9;
    localparam logic [3:0] TK_UNTERM = 4'd10;

    // character classes set by the front end
    localparam logic [2:0] CLS_OTHER  = 3'd0;
    localparam logic [2:0] CLS_EOI    = 3'd1;
    localparam logic [2:0] CLS_LT     = 3'd2;
    localparam logic [2:0] CLS_GT     = 3'd3;
    localparam logic [2:0] CLS_EQ     = 3'd4;
    localparam logic [2:0] CLS_QUOTE  = 3'd5;
    localparam logic [2:0] CLS_DIGIT  = 3'd6;
    localparam logic [2:0] CLS_LETTER = 3'd7;

    // special characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // classified character as it sits in the queue
    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] cls;
    } t_entry;

    // one output word
    typedef struct packed {
        logic [3:0] ttype;
        logic       has_char;
        logic [7:0] ch;
        logic       done;
        logic       last;
    } t_res;

endpackage

### design/sts_front.sv
// front end: input handshake and character classification
// depends on sts_pkg; feeds sts_queue
module sts_front (
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_char,
    input  logic            i_eoi,
    input  logic            i_full,
    output logic            o_push,
    output sts_pkg::t_entry o_entry
);

    // accept whenever the queue has room
    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    // classify the character
    always_comb begin
        o_entry.ch  = i_char;
        o_entry.cls = sts_pkg::CLS_OTHER;
        if (i_eoi) begin
            o_entry.cls = sts_pkg::CLS_EOI;
        end else if (i_char == sts_pkg::CH_LT) begin
            o_entry.cls = sts_pkg::CLS_LT;
        end else if (i_char == sts_pkg::CH_GT) begin
            o_entry.cls = sts_pkg::CLS_GT;
        end else if (i_char == sts_pkg::CH_EQ) begin
            o_entry.cls = sts_pkg::CLS_EQ;
        end else if (i_char == sts_pkg::CH_QUOTE) begin
            o_entry.cls = sts_pkg::CLS_QUOTE;
        end else if (i_char >= sts_pkg::CH_0 && i_char <= sts_pkg::CH_9) begin
            o_entry.cls = sts_pkg::CLS_DIGIT;
        end else if ((i_char >= sts_pkg::CH_UA && i_char <= sts_pkg::CH_UZ) ||
                     (i_char >= sts_pkg::CH_LA && i_char <= sts_pkg::CH_LZ)) begin
            o_entry.cls = sts_pkg::CLS_LETTER;
        end
    end

endmodule

### design/sts_queue.sv
// short queue of classified characters between front and back end
// depends on sts_pkg
module sts_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sts_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    output sts_pkg::t_entry o_entry,
    input  logic            i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sts_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### design/sts_back.sv
// back end: scanner mode machine, output register and second-word holding stage
// depends on sts_pkg; pops from sts_queue
module sts_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sts_pkg::t_entry i_q_entry,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output sts_pkg::t_res   o_res
);

    logic [2:0]    r_mode, n_mode;
    logic          r_out_valid;
    sts_pkg::t_res r_out;
    logic          r_pend_valid;
    sts_pkg::t_res r_pend;

    logic          out_free;
    sts_pkg::t_res res0, res1, idle_res;
    logic [1:0]    cnt;
    logic          idle_cnt;
    logic [2:0]    idle_mode;
    logic [3:0]    with_eq, alone, run_type;
    sts_pkg::t_res blank;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_pop      = i_q_valid && !r_pend_valid && out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;

    assign blank = '{ttype: sts_pkg::TK_EOF, has_char: 1'b0, ch: 8'h00,
                     done: 1'b0, last: 1'b0};

    // outcome of scanning the character from idle
    always_comb begin
        idle_res  = blank;
        idle_cnt  = 1'b0;
        idle_mode = sts_pkg::MODE_IDLE;
        unique case (i_q_entry.cls)
            sts_pkg::CLS_EOI: begin
                idle_res.done = 1'b1;
                idle_cnt      = 1'b1;
            end
            sts_pkg::CLS_LT:    idle_mode = sts_pkg::MODE_LT;
            sts_pkg::CLS_GT:    idle_mode = sts_pkg::MODE_GT;
            sts_pkg::CLS_EQ:    idle_mode = sts_pkg::MODE_EQ;
            sts_pkg::CLS_QUOTE: idle_mode = sts_pkg::MODE_STR;
            sts_pkg::CLS_DIGIT: begin
                idle_res.ttype    = sts_pkg::TK_NUMBER;
                idle_res.has_char = 1'b1;
                idle_res.ch       = i_q_entry.ch;
                idle_cnt          = 1'b1;
                idle_mode         = sts_pkg::MODE_NUM;
            end
            sts_pkg::CLS_LETTER: begin
                idle_res.ttype    = sts_pkg::TK_NAME;
                idle_res.has_char = 1'b1;
                idle_res.ch       = i_q_entry.ch;
                idle_cnt          = 1'b1;
                idle_mode         = sts_pkg::MODE_NAME;
            end
            default: ;
        endcase
    end

    // token types for operator and run modes
    always_comb begin
        unique case (r_mode)
            sts_pkg::MODE_LT: begin
                with_eq = sts_pkg::TK_LE;
                alone   = sts_pkg::TK_LT;
            end
            sts_pkg::MODE_GT: begin
                with_eq = sts_pkg::TK_GE;
                alone   = sts_pkg::TK_GT;
            end
            default: begin
                with_eq = sts_pkg::TK_EQ;
                alone   = sts_pkg::TK_ASSIGN;
            end
        endcase
        run_type = (r_mode == sts_pkg::MODE_NUM) ? sts_pkg::TK_NUMBER : sts_pkg::TK_NAME;
    end

    // mode machine: up to two words per character
    always_comb begin
        res0   = idle_res;
        res1   = blank;
        cnt    = {1'b0, idle_cnt};
        n_mode = idle_mode;
        unique case (r_mode) inside
            sts_pkg::MODE_LT, sts_pkg::MODE_GT, sts_pkg::MODE_EQ: begin
                res0      = blank;
                res0.done = 1'b1;
                if (i_q_entry.cls == sts_pkg::CLS_EQ) begin
                    res0.ttype = with_eq;
                    cnt        = 2'd1;
                    n_mode     = sts_pkg::MODE_IDLE;
                end else begin
                    res0.ttype = alone;
                    res1       = idle_res;
                    cnt        = 2'd1 + {1'b0, idle_cnt};
                end
            end
            sts_pkg::MODE_STR: begin
                res0       = blank;
                res0.ttype = sts_pkg::TK_STRING;
                cnt        = 2'd1;
                if (i_q_entry.cls == sts_pkg::CLS_EOI) begin
                    res0.ttype = sts_pkg::TK_UNTERM;
                    res0.done  = 1'b1;
                    n_mode     = sts_pkg::MODE_IDLE;
                end else if (i_q_entry.cls == sts_pkg::CLS_QUOTE) begin
                    res0.done = 1'b1;
                    n_mode    = sts_pkg::MODE_IDLE;
                end else begin
                    res0.has_char = 1'b1;
                    res0.ch       = i_q_entry.ch;
                    n_mode        = sts_pkg::MODE_STR;
                end
            end
            sts_pkg::MODE_NUM, sts_pkg::MODE_NAME: begin
                res0       = blank;
                res0.ttype = run_type;
                if (i_q_entry.cls == sts_pkg::CLS_DIGIT ||
                    i_q_entry.cls == sts_pkg::CLS_LETTER) begin
                    res0.has_char = 1'b1;
                    res0.ch       = i_q_entry.ch;
                    cnt           = 2'd1;
                    n_mode        = r_mode;
                end else begin
                    // terminator ends the run and is scanned again from idle
                    res0.done = 1'b1;
                    res1      = idle_res;
                    cnt       = 2'd1 + {1'b0, idle_cnt};
                end
            end
            default: ;
        endcase
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sts_pkg::MODE_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode <= n_mode;
            end
            if (out_free) begin
                r_out_valid <= r_pend_valid || (o_pop && cnt != 2'd0);
            end
            if (r_pend_valid && out_free) begin
                r_pend_valid <= 1'b0;
            end else if (o_pop && cnt == 2'd2) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    // output word and held second word
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (o_pop) begin
                r_out <= res0;
            end
        end
        if (o_pop && cnt == 2'd2) begin
            r_pend <= res1;
        end
    end

    // a held second word always waits behind a word on the output
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("second word held without an output word");

    // a two-word character leaves its second word held
    a_two_words_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && cnt == 2'd2) |=> r_pend_valid)
        else $error("second word of a character lost");

    // a character word never closes a token
    a_char_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.has_char && r_out.done))
        else $error("word carries both a character and a token end");

    // only strings, numbers and names carry characters
    a_char_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.has_char) |->
            (r_out.ttype == sts_pkg::TK_STRING || r_out.ttype == sts_pkg::TK_NUMBER ||
             r_out.ttype == sts_pkg::TK_NAME))
        else $error("character word with an operator or end type");

    // the first word of a character is not its last when a second follows
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && out_free && cnt == 2'd2) |=> (r_out_valid && !r_out.last))
        else $error("first of two words marked last");

endmodule

### design/script_token_scanner.sv
// top level of the script token scanner: stream ports, front end, queue, back end
// depends on sts_pkg, sts_front, sts_queue and sts_back
//
// Takes one source byte per word (tuser set = end of input) and streams out token
// words: a character word for every string, number or name character and a
// token-end word carrying the token type. A byte that gives one word or none is
// taken every cycle unless the output stalls; a byte that ends a token and starts another (an operator
// followed by a token start, or the byte that ends a number or name) gives two
// words, and its second word waits in the holding register while the next byte is held back.
// The first word of a byte passes through the queue and then the output register;
// a QUEUE_DEPTH-entry queue lets the input keep running while the output stalls.
module script_token_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_char
    input  logic [0:0] i_s_tuser,   // [0] end_of_input
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] char_value
    output logic [5:0] o_m_tuser,   // [3:0] token_type, [4] has_char, [5] token_done
    output logic       o_m_tlast    // last word caused by one input byte
);

    logic            full;
    logic            push;
    sts_pkg::t_entry push_entry;
    logic            q_valid;
    sts_pkg::t_entry q_entry;
    logic            pop;
    sts_pkg::t_res   res;

    // classify and push
    sts_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_char     (i_s_tdata),
        .i_eoi      (i_s_tuser[0]),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // decoupling queue
    sts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    // scan and emit
    sts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (res)
    );

    // pack the output word
    assign o_m_tdata = res.ch;
    assign o_m_tuser = {res.done, res.has_char, res.ttype};
    assign o_m_tlast = res.last;

endmodule

### dv/tb.sv
// self-checking testbench for script_token_scanner: directed rows, then random token streams
// depends on sts_pkg and script_token_scanner; predicts every output word in place
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam int N_DIR = 26;
    localparam int N_RANDOM = 1250;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam sts_pkg::t_res NO_WORD = '0;

    // one source byte as it goes on the input stream, with an optional typed-in result
    typedef struct packed {
        logic [7:0]    ch;
        logic          eoi;
        logic          typed;
        sts_pkg::t_res want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // [7:0] in_char
    logic [0:0] i_s_tuser = 1'b0;    // [0] end_of_input
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] char_value
    logic [5:0] o_m_tuser;           // [3:0] token_type, [4] has_char, [5] token_done
    logic       o_m_tlast;

    script_token_scanner u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // token predictor state and the words it expects
    logic [2:0]    lex_mode = sts_pkg::MODE_IDLE;
    sts_pkg::t_res step_words[$];
    sts_pkg::t_res pending_words[$];
    t_row          dir_rows[N_DIR];
    t_row          rand_rows[$];
    int            n_fail = 0;
    int            burst_left = 0;
    int            idle_cycles = 0;
    int            rx_cycle = 0;

    function automatic sts_pkg::t_res mk_word(logic [3:0] kind, logic has, logic [7:0] c,
                                              logic done, logic last);
        sts_pkg::t_res w;
        w.ttype = kind;
        w.has_char = has;
        w.ch = c;
        w.done = done;
        w.last = last;
        return w;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= sts_pkg::CH_0 && c <= sts_pkg::CH_9;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= sts_pkg::CH_LA && c <= sts_pkg::CH_LZ) ||
               (c >= sts_pkg::CH_UA && c <= sts_pkg::CH_UZ);
    endfunction

    // scan one byte as the start of a new token
    function void scan_fresh(logic [7:0] c, logic eoi);
        if (eoi)
            step_words.push_back(mk_word(sts_pkg::TK_EOF, 1'b0, 8'h00, 1'b1, 1'b0));
        else if (c == sts_pkg::CH_LT)
            lex_mode = sts_pkg::MODE_LT;
        else if (c == sts_pkg::CH_GT)
            lex_mode = sts_pkg::MODE_GT;
        else if (c == sts_pkg::CH_EQ)
            lex_mode = sts_pkg::MODE_EQ;
        else if (c == sts_pkg::CH_QUOTE)
            lex_mode = sts_pkg::MODE_STR;
        else if (is_digit(c)) begin
            lex_mode = sts_pkg::MODE_NUM;
            step_words.push_back(mk_word(sts_pkg::TK_NUMBER, 1'b1, c, 1'b0, 1'b0));
        end else if (is_letter(c)) begin
            lex_mode = sts_pkg::MODE_NAME;
            step_words.push_back(mk_word(sts_pkg::TK_NAME, 1'b1, c, 1'b0, 1'b0));
        end
    endfunction

    // words caused by one accepted byte, left in step_words
    function void scan_predict(logic [7:0] c, logic eoi);
        logic [3:0] with_eq;
        logic [3:0] alone;
        logic [3:0] kind;
        step_words.delete();
        case (lex_mode) inside
            sts_pkg::MODE_LT, sts_pkg::MODE_GT, sts_pkg::MODE_EQ: begin
                with_eq = (lex_mode == sts_pkg::MODE_LT) ? sts_pkg::TK_LE :
                          (lex_mode == sts_pkg::MODE_GT) ? sts_pkg::TK_GE : sts_pkg::TK_EQ;
                alone = (lex_mode == sts_pkg::MODE_LT) ? sts_pkg::TK_LT :
                        (lex_mode == sts_pkg::MODE_GT) ? sts_pkg::TK_GT : sts_pkg::TK_ASSIGN;
                lex_mode = sts_pkg::MODE_IDLE;
                if (!eoi && c == sts_pkg::CH_EQ)
                    step_words.push_back(mk_word(with_eq, 1'b0, 8'h00, 1'b1, 1'b0));
                else begin
                    step_words.push_back(mk_word(alone, 1'b0, 8'h00, 1'b1, 1'b0));
                    scan_fresh(c, eoi);
                end
            end
            sts_pkg::MODE_STR: begin
                if (eoi) begin
                    lex_mode = sts_pkg::MODE_IDLE;
                    step_words.push_back(mk_word(sts_pkg::TK_UNTERM, 1'b0, 8'h00, 1'b1, 1'b0));
                end else if (c == sts_pkg::CH_QUOTE) begin
                    lex_mode = sts_pkg::MODE_IDLE;
                    step_words.push_back(mk_word(sts_pkg::TK_STRING, 1'b0, 8'h00, 1'b1, 1'b0));
                end else
                    step_words.push_back(mk_word(sts_pkg::TK_STRING, 1'b1, c, 1'b0, 1'b0));
            end
            sts_pkg::MODE_NUM, sts_pkg::MODE_NAME: begin
                kind = (lex_mode == sts_pkg::MODE_NUM) ? sts_pkg::TK_NUMBER : sts_pkg::TK_NAME;
                if (!eoi && (is_digit(c) || is_letter(c)))
                    step_words.push_back(mk_word(kind, 1'b1, c, 1'b0, 1'b0));
                else begin
                    lex_mode = sts_pkg::MODE_IDLE;
                    step_words.push_back(mk_word(kind, 1'b0, 8'h00, 1'b1, 1'b0));
                    scan_fresh(c, eoi);
                end
            end
            default: begin
                lex_mode = sts_pkg::MODE_IDLE;
                scan_fresh(c, eoi);
            end
        endcase
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(sts_pkg::CH_UA + r) : 8'(sts_pkg::CH_LA + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 10) ? 8'(sts_pkg::CH_0 + r) :
               (r < 36) ? 8'(sts_pkg::CH_UA + r - 10) : 8'(sts_pkg::CH_LA + r - 36);
    endfunction

    function void add_byte(logic [7:0] c, logic eoi);
        rand_rows.push_back('{c, eoi, 1'b0, NO_WORD});
    endfunction

    // random token streams: mostly well-formed tokens, some noise and broken strings
    function void build_random();
        int pick;
        int len;
        logic [7:0] c;
        while (rand_rows.size() < N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                case ($urandom_range(0, 2))
                    0: add_byte(sts_pkg::CH_LT, 1'b0);
                    1: add_byte(sts_pkg::CH_GT, 1'b0);
                    default: add_byte(sts_pkg::CH_EQ, 1'b0);
                endcase
                if ($urandom_range(0, 1))
                    add_byte(sts_pkg::CH_EQ, 1'b0);
            end else if (pick < 32) begin
                add_byte(sts_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    c = 8'($urandom_range(0, 255));
                    add_byte((c == sts_pkg::CH_QUOTE) ? CH_SP : c, 1'b0);
                end
                pick = $urandom_range(0, 19);
                if (pick < 17)
                    add_byte(sts_pkg::CH_QUOTE, 1'b0);
                else if (pick < 19)
                    add_byte(8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 50) begin
                add_byte(8'(sts_pkg::CH_0 + $urandom_range(0, 9)), 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) add_byte(rand_alnum(), 1'b0);
            end else if (pick < 68) begin
                add_byte(rand_letter(), 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) add_byte(rand_alnum(), 1'b0);
            end else if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0: add_byte(CH_SP, 1'b0);
                    1: add_byte(CH_CR, 1'b0);
                    default: add_byte(CH_LF, 1'b0);
                endcase
            end else if (pick < 93)
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            else
                add_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    // drive one byte in bursts with random gaps; called and returning at a falling edge
    task automatic send_byte(input t_row row);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= row.ch;
        i_s_tuser <= row.eoi;
        do @(posedge i_clk); while (!o_s_tready);
        scan_predict(row.ch, row.eoi);
        if (row.typed)
            pending_words.push_back(row.want);
        else
            foreach (step_words[k]) pending_words.push_back(step_words[k]);
        @(negedge i_clk);
    endtask

    // main sequence
    initial begin
        dir_rows = '{
            '{8'hFF, 1'b1, 1'b1,
              mk_word(sts_pkg::TK_EOF, 1'b0, 8'h00, 1'b1, 1'b1)},
            '{sts_pkg::CH_LT, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_EQ, 1'b0, 1'b1,
              mk_word(sts_pkg::TK_LE, 1'b0, 8'h00, 1'b1, 1'b1)},
            '{sts_pkg::CH_GT, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_UA, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_LZ, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_EQ, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_EQ, 1'b0, 1'b1,
              mk_word(sts_pkg::TK_EQ, 1'b0, 8'h00, 1'b1, 1'b1)},
            '{sts_pkg::CH_EQ, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b1, 1'b0, NO_WORD},
            '{sts_pkg::CH_0, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_9, 1'b0, 1'b0, NO_WORD},
            '{8'h80, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_QUOTE, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b1,
              mk_word(sts_pkg::TK_STRING, 1'b1, 8'h00, 1'b0, 1'b1)},
            '{8'hFF, 1'b0, 1'b1,
              mk_word(sts_pkg::TK_STRING, 1'b1, 8'hFF, 1'b0, 1'b1)},
            '{sts_pkg::CH_LT, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_QUOTE, 1'b0, 1'b1,
              mk_word(sts_pkg::TK_STRING, 1'b0, 8'h00, 1'b1, 1'b1)},
            '{sts_pkg::CH_QUOTE, 1'b0, 1'b0, NO_WORD},
            '{8'h5A, 1'b1, 1'b1,
              mk_word(sts_pkg::TK_UNTERM, 1'b0, 8'h00, 1'b1, 1'b1)},
            '{CH_CR, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_UZ, 1'b0, 1'b0, NO_WORD},
            '{8'hFF, 1'b1, 1'b0, NO_WORD},
            '{sts_pkg::CH_LT, 1'b0, 1'b0, NO_WORD},
            '{sts_pkg::CH_LT, 1'b0, 1'b0, NO_WORD},
            '{CH_LF, 1'b0, 1'b0, NO_WORD}
        };
        build_random();

        // hold reset, then release at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_byte(dir_rows[i]);
        foreach (rand_rows[i])
            send_byte(rand_rows[i]);
        i_s_tvalid <= 1'b0;

        // drain, then give late extra words a chance to show up
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // output receiver: stall pattern chosen by bits [9:8] of the cycle counter
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: i_m_tready <= 1'($urandom_range(0, 1));
            default: i_m_tready <= ((rx_cycle % 7) >= 3);
        endcase
    end

    // check each accepted word against the oldest pending one
    always @(posedge i_clk) begin
        sts_pkg::t_res got;
        sts_pkg::t_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.ttype = o_m_tuser[3:0];
            got.has_char = o_m_tuser[4];
            got.ch = o_m_tdata;
            got.done = o_m_tuser[5];
            got.last = o_m_tlast;
            if (pending_words.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected word type %0d has %0b char %h done %0b last %0b",
                         $realtime, got.ttype, got.has_char, got.ch, got.done, got.last);
            end else begin
                want = pending_words.pop_front();
                if (got.ttype !== want.ttype || got.has_char !== want.has_char ||
                    got.ch !== want.ch || got.done !== want.done || got.last !== want.last) begin
                    n_fail++;
                    $display("%0t: expected type %0d has %0b char %h done %0b last %0b",
                             $realtime, want.ttype, want.has_char, want.ch, want.done,
                             want.last);
                    $display("%0t:   actual type %0d has %0b char %h done %0b last %0b",
                             $realtime, got.ttype, got.has_char, got.ch, got.done, got.last);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

endmodule
